// ===== sv/keq_pkg.sv =====
// Package for the keyed event queue: sizes, request kinds, entry and state types.
package keq_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_COUNT = 2'd2;

    localparam logic [5:0] MATCH_MAX = 6'd63;

    typedef struct packed {
        logic [7:0]  button;
        logic [31:0] sequence_num;
        logic        level;
        logic [31:0] time_stamp;
    } entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

// ===== sv/keyed_event_queue_overwrite_oldest.sv =====
// Keyed event queue: age-ordered button event store with overwrite of the oldest entry.
// Push: result registered at the accepting edge; a new push is taken while the last result is read (out_ready).
// Pop and count: one compare per cycle from the oldest slot up; a pop answers at its first hit,
// a miss or count once every filled slot is scanned. No new request is taken while scanning,
// nor while an unread result is held. The scan compare and slot counter set the pace.
// Reset (rst_n low, asynchronous) empties the store; entry contents are not cleared.
module keyed_event_queue_overwrite_oldest
    import keq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  button,
    input  logic [31:0] sequence_req,
    input  logic        level,
    input  logic [31:0] timestamp,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic        overwrote,
    output logic [5:0]  match_count,
    output logic [31:0] out_sequence,
    output logic        out_level,
    output logic [31:0] out_timestamp
);

    entry_t             entry_reg [DEPTH];
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [7:0]         key_reg;
    logic [7:0]         key_next;
    logic [1:0]         op_reg;
    logic [1:0]         op_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               status_reg;
    logic               status_next;
    logic               overwrote_reg;
    logic               overwrote_next;
    logic [5:0]         match_count_reg;
    logic [5:0]         match_count_next;
    logic [31:0]        out_sequence_reg;
    logic [31:0]        out_sequence_next;
    logic               out_level_reg;
    logic               out_level_next;
    logic [31:0]        out_timestamp_reg;
    logic [31:0]        out_timestamp_next;

    logic               accept;
    logic               hit;
    logic               at_end;
    logic               shift_en;
    logic [CNT_W-1:0]   shift_pos;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    entry_t             wr_data;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign hit      = (entry_reg[idx_reg[IDX_W-1:0]].button == key_reg);
    assign at_end   = (idx_reg == fill_reg);

    always_comb
    begin
        state_next         = state_reg;
        fill_next          = fill_reg;
        idx_next           = idx_reg;
        cnt_next           = cnt_reg;
        key_next           = key_reg;
        op_next            = op_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        status_next        = status_reg;
        overwrote_next     = overwrote_reg;
        match_count_next   = match_count_reg;
        out_sequence_next  = out_sequence_reg;
        out_level_next     = out_level_reg;
        out_timestamp_next = out_timestamp_reg;
        shift_en           = 1'b0;
        shift_pos          = '0;
        wr_en              = 1'b0;
        wr_idx             = fill_reg[IDX_W-1:0];
        wr_data.button       = button;
        wr_data.sequence_num = sequence_req;
        wr_data.level        = level;
        wr_data.time_stamp   = timestamp;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next        = 1'b0;
                    overwrote_next     = 1'b0;
                    match_count_next   = '0;
                    out_sequence_next  = '0;
                    out_level_next     = 1'b0;
                    out_timestamp_next = '0;
                    key_next           = button;
                    op_next            = kind;
                    idx_next           = '0;
                    cnt_next           = '0;
                    case (kind)
                        KIND_PUSH:
                        begin
                            wr_en          = 1'b1;
                            out_valid_next = 1'b1;
                            if (fill_reg == CNT_W'(DEPTH))
                            begin
                                // drop the oldest, append at the top slot
                                shift_en       = 1'b1;
                                wr_idx         = IDX_W'(DEPTH - 1);
                                overwrote_next = 1'b1;
                            end
                            else
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        KIND_POP, KIND_COUNT:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (at_end)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (op_reg == KIND_POP)
                    begin
                        status_next = 1'b1;
                    end
                    else if (32'(cnt_reg) > 32'(MATCH_MAX))
                    begin
                        match_count_next = MATCH_MAX;
                    end
                    else
                    begin
                        match_count_next = 6'(cnt_reg);
                    end
                end
                else if (hit && op_reg == KIND_POP)
                begin
                    out_sequence_next  = entry_reg[idx_reg[IDX_W-1:0]].sequence_num;
                    out_level_next     = entry_reg[idx_reg[IDX_W-1:0]].level;
                    out_timestamp_next = entry_reg[idx_reg[IDX_W-1:0]].time_stamp;
                    shift_en           = 1'b1;
                    shift_pos          = idx_reg;
                    fill_next          = fill_reg - 1'b1;
                    out_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
                else
                begin
                    if (hit)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg           <= idx_next;
        cnt_reg           <= cnt_next;
        key_reg           <= key_next;
        op_reg            <= op_next;
        status_reg        <= status_next;
        overwrote_reg     <= overwrote_next;
        match_count_reg   <= match_count_next;
        out_sequence_reg  <= out_sequence_next;
        out_level_reg     <= out_level_next;
        out_timestamp_reg <= out_timestamp_next;
    end

    // advance younger entries one slot toward the oldest end
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DEPTH - 1; j++)
        begin
            if (shift_en && (CNT_W'(j) >= shift_pos))
            begin
                entry_reg[j] <= entry_reg[j + 1];
            end
        end
        if (wr_en)
        begin
            entry_reg[wr_idx] <= wr_data;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign overwrote     = overwrote_reg;
    assign match_count   = match_count_reg;
    assign out_sequence  = out_sequence_reg;
    assign out_level     = out_level_reg;
    assign out_timestamp = out_timestamp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_POP || kind == KIND_COUNT)) |=> (state_reg == ST_SCAN))
        else $error("pop or count request did not start a scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_PUSH && fill_reg != CNT_W'(DEPTH))
        |=> (fill_reg == $past(fill_reg) + 1'b1) && out_valid)
        else $error("push into non-full store did not grow the fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (out_sequence == '0 && out_timestamp == '0 && !out_level))
        else $error("failed pop carries event data");

endmodule
